// ===== rtl/rg2fb_pkg.sv =====
// Package for the rotated 2-bit gray framebuffer plotter.
// Holds the panel geometry, derived store sizes, command and rotation codes
// and the controller state type. It depends on nothing else.
package rg2fb_pkg;

    localparam int PANEL_WIDTH  = 300;
    localparam int PANEL_HEIGHT = 400;

    localparam int STORE_COLS  = (PANEL_WIDTH + 1) / 2;
    localparam int STORE_ROWS  = (PANEL_HEIGHT + 1) / 2;
    localparam int STORE_DEPTH = STORE_COLS * STORE_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int XW      = $clog2(PANEL_WIDTH);
    localparam int YW      = $clog2(PANEL_HEIGHT);
    localparam int MAX_XY  = (XW > YW) ? XW : YW;
    localparam int COORD_W = ((MAX_XY > 9) ? MAX_XY : 9) + 2;

    localparam int          BYTE_TOP_BIT = 7;
    localparam logic [1:0]  GRAY_MASK    = 2'h3;

    typedef enum logic [1:0] {
        CMD_PLOT = 2'd0,
        CMD_FILL = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLOT_RD,
        ST_PLOT_WR,
        ST_READ_RD,
        ST_READ_DONE,
        ST_FILL,
        ST_RESP
    } state_t;

endpackage

// ===== rtl/rotated_gray2_framebuffer_plotter.sv =====
// Top level of the rotated 2-bit gray framebuffer plotter.
// Holds the frame memory, the command sequencer and the result register.
// Depends on rg2fb_pkg for geometry, codes and the state type.
//
// Usage: commands arrive on the s_ channel (valid/ready); each command gives
// exactly one result transfer on the m_ channel (read_data, status). The
// rotation register is written through the cfg channel, which is always
// ready; the user must write it only while the block is idle, and the
// block itself does not enforce this. An in-panel plot or an in-range
// read is accepted in the idle state, reads the frame memory in the next
// cycle and loads the result register from the state that follows the
// read (ST_PLOT_WR or ST_READ_DONE); the next command is taken only once
// the sequencer is back in the idle state. The single memory port makes a
// plot need both states: one read and one write back per plot. An
// off-panel plot, an out-of-range read and the unused command code skip
// the memory access and load their result from their first state.
// A fill writes one byte per cycle over all STORE_DEPTH bytes (30000 for
// the 300x400 panel). After reset the block sweeps the memory to zero, one
// byte per cycle over every address, and holds s_ready low during the sweep.
// A finished result waits in the output register while the receiver stalls;
// the sequencer parks its result and resumes only once it has been moved
// into the output register.
module rotated_gray2_framebuffer_plotter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_rotation,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [8:0]  s_pixel_x,
    input  logic [8:0]  s_pixel_y,
    input  logic [1:0]  s_shade,
    input  logic [7:0]  s_fill_value,
    input  logic [14:0] s_byte_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_status
);
    import rg2fb_pkg::*;

    localparam logic signed [COORD_W-1:0] W_S  = COORD_W'(PANEL_WIDTH);
    localparam logic signed [COORD_W-1:0] H_S  = COORD_W'(PANEL_HEIGHT);
    localparam logic signed [COORD_W-1:0] W1_S = COORD_W'(PANEL_WIDTH - 1);
    localparam logic signed [COORD_W-1:0] H1_S = COORD_W'(PANEL_HEIGHT - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(STORE_DEPTH - 1);

    logic [7:0] frame_mem [STORE_DEPTH];
    logic [7:0] mem_rdata_reg;
    logic       mem_we;
    logic       mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0] mem_wdata;

    state_t state_reg, state_next;
    logic [1:0] rot_reg, rot_next;
    logic signed [COORD_W-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic [1:0]  gray_reg, gray_next;
    logic [7:0]  fill_reg, fill_next;
    logic [14:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [2:0]  bit_hi_reg, bit_hi_next;
    logic [7:0]  res_data_reg, res_data_next;
    logic        res_status_reg, res_status_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_data_reg, m_data_next;
    logic        m_status_reg, m_status_next;

    logic signed [COORD_W-1:0] px_s, py_s;
    logic        out_free;
    logic        fin_valid;
    logic [7:0]  fin_data;
    logic        fin_status;
    logic        off_panel;
    logic [2:0]  bit_lo;
    logic [7:0]  bit_mask;
    logic [7:0]  bit_set;

    assign px_s      = COORD_W'(s_pixel_x);
    assign py_s      = COORD_W'(s_pixel_y);
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_read_data = m_data_reg;
    assign m_status  = m_status_reg;

    assign off_panel = (tx_reg < 0) || (ty_reg < 0) || (tx_reg >= W_S) || (ty_reg >= H_S);
    assign bit_lo    = bit_hi_reg - 3'd2;
    assign bit_mask  = (8'd1 << bit_hi_reg) | (8'd1 << bit_lo);
    assign bit_set   = ((gray_reg[1] ? 8'd1 : 8'd0) << bit_hi_reg)
                     | ((gray_reg[0] ? 8'd1 : 8'd0) << bit_lo);

    always_comb begin
        state_next      = state_reg;
        rot_next        = rot_reg;
        tx_next         = tx_reg;
        ty_next         = ty_reg;
        gray_next       = gray_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        addr_next       = addr_reg;
        bit_hi_next     = bit_hi_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_status_next   = m_status_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = addr_reg;
        mem_wdata       = 8'h00;
        fin_valid       = 1'b0;
        fin_data        = 8'h00;
        fin_status      = 1'b0;

        if (cfg_valid && cfg_ready) begin
            rot_next = cfg_rotation;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = cnt_reg;
                mem_wdata = 8'h00;
                if (cnt_reg == LAST_ADDR) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    gray_next       = s_shade & GRAY_MASK;
                    fill_next       = s_fill_value;
                    idx_next        = s_byte_index;
                    cnt_next        = '0;
                    res_data_next   = 8'h00;
                    res_status_next = 1'b0;
                    case (rot_t'(rot_reg))
                        ROT_90: begin
                            tx_next = W1_S - py_s;
                            ty_next = px_s;
                        end
                        ROT_180: begin
                            tx_next = W1_S - px_s;
                            ty_next = H1_S - py_s;
                        end
                        ROT_270: begin
                            tx_next = py_s;
                            ty_next = H1_S - px_s;
                        end
                        default: begin
                            tx_next = px_s;
                            ty_next = py_s;
                        end
                    endcase
                    case (cmd_t'(s_cmd))
                        CMD_PLOT: state_next = ST_PLOT_RD;
                        CMD_FILL: state_next = ST_FILL;
                        CMD_READ: state_next = ST_READ_RD;
                        default:  state_next = ST_RESP;
                    endcase
                end
            end
            ST_PLOT_RD: begin
                if (off_panel) begin
                    fin_valid  = 1'b1;
                    fin_status = 1'b1;
                end else begin
                    mem_addr = ADDR_W'(ADDR_W'(ty_reg[COORD_W-2:1]) * ADDR_W'(STORE_COLS)
                                       + ADDR_W'(tx_reg[COORD_W-2:1]));
                    mem_re      = 1'b1;
                    addr_next   = mem_addr;
                    bit_hi_next = 3'(BYTE_TOP_BIT) - {tx_reg[0], 1'b0, ty_reg[0]};
                    state_next  = ST_PLOT_WR;
                end
            end
            ST_PLOT_WR: begin
                mem_we    = 1'b1;
                mem_addr  = addr_reg;
                mem_wdata = (mem_rdata_reg & ~bit_mask) | bit_set;
                fin_valid = 1'b1;
            end
            ST_READ_RD: begin
                if (32'(idx_reg) < 32'(STORE_DEPTH)) begin
                    mem_re     = 1'b1;
                    mem_addr   = ADDR_W'(idx_reg);
                    state_next = ST_READ_DONE;
                end else begin
                    fin_valid = 1'b1;
                end
            end
            ST_READ_DONE: begin
                fin_valid = 1'b1;
                fin_data  = mem_rdata_reg;
            end
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_addr  = cnt_reg;
                mem_wdata = fill_reg;
                if (cnt_reg == LAST_ADDR) begin
                    cnt_next  = '0;
                    fin_valid = 1'b1;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RESP: begin
                fin_valid  = 1'b1;
                fin_data   = res_data_reg;
                fin_status = res_status_reg;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (fin_valid) begin
            if (out_free) begin
                m_valid_next  = 1'b1;
                m_data_next   = fin_data;
                m_status_next = fin_status;
                state_next    = ST_IDLE;
            end else begin
                res_data_next   = fin_data;
                res_status_next = fin_status;
                state_next      = ST_RESP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            rot_reg     <= ROT_0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rot_reg     <= rot_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tx_reg         <= tx_next;
        ty_reg         <= ty_next;
        gray_reg       <= gray_next;
        fill_reg       <= fill_next;
        idx_reg        <= idx_next;
        addr_reg       <= addr_next;
        bit_hi_reg     <= bit_hi_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
        m_status_reg   <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= frame_mem[mem_addr];
        end
    end

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_PLOT_WR || state_reg == ST_FILL || state_reg == ST_CLEAR))
        else $error("frame memory written outside a write state");

    a_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we || mem_re) |-> (32'(mem_addr) < 32'(STORE_DEPTH)))
        else $error("frame memory address beyond the store");

    a_no_rw_same_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("read and write on the single memory port together");

    a_error_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_read_data == 8'h00))
        else $error("off-panel result carries read data");

    a_plot_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PLOT_WR) |-> $past(mem_re))
        else $error("plot write back without a preceding read");

endmodule
